@@ src/pct_pkg.sv @@
// shared types and constants for the partition count table
// no dependencies
package pct_pkg;

    localparam int QUERY_W = 6;
    localparam int COUNT_W = 21;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic load_query;
        logic fill_start;
        logic fill_rd;
        logic fill_wr;
        logic query_rd;
        logic out_load;
    } pct_cmd_t;

    typedef struct packed {
        logic fill_last;
    } pct_status_t;

endpackage

@@ src/pct_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module pct_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/pct_ctrl.sv @@
// controller: table fill sequencing, query read and output handshake
// depends on pct_pkg
module pct_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  pct_pkg::pct_status_t status,
    output pct_pkg::pct_cmd_t    cmd
);

    import pct_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL_RD,
        S_FILL_WR,
        S_QUERY_RD,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   filled_reg, filled_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        filled_next    = filled_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_query = 1'b1;
                    cmd.fill_start = !filled_reg;
                    state_next     = filled_reg ? S_QUERY_RD : S_FILL_RD;
                end
            end
            S_FILL_RD:
            begin
                cmd.fill_rd = 1'b1;
                state_next  = S_FILL_WR;
            end
            S_FILL_WR:
            begin
                cmd.fill_wr = 1'b1;
                if (status.fill_last)
                begin
                    filled_next = 1'b1;
                    state_next  = S_QUERY_RD;
                end
                else
                begin
                    state_next = S_FILL_RD;
                end
            end
            S_QUERY_RD:
            begin
                cmd.query_rd = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            filled_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            filled_reg    <= filled_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/pct_dp.sv @@
// datapath: query registers, fill counters, recurrence adder and count table
// depends on pct_pkg and pct_ram
module pct_dp #(
    parameter int MAX_N = 64
) (
    input  logic                          clk,
    input  logic [pct_pkg::QUERY_W-1:0]   query_total,
    input  logic [pct_pkg::QUERY_W-1:0]   largest_part,
    output logic [pct_pkg::COUNT_W-1:0]   partition_count,
    input  pct_pkg::pct_cmd_t             cmd,
    output pct_pkg::pct_status_t          status
);

    import pct_pkg::*;

    localparam int IW    = $clog2(MAX_N);
    localparam int XW    = (IW > QUERY_W) ? IW : QUERY_W;
    localparam int DEPTH = 1 << (2 * IW);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_N - 1);

    logic [IW-1:0]      n_q_reg, m_q_reg;
    logic               oor_reg;
    logic [IW-1:0]      fn_reg, fn_next, fm_reg, fm_next;
    logic [COUNT_W-1:0] prev_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [QUERY_W-1:0] m_clip;
    logic [XW-1:0]      n_ext, m_ext;
    logic [IW-1:0]      rest, lim;
    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] entry;
    logic               rd_en;
    logic [2*IW-1:0]    rd_addr;
    logic [COUNT_W-1:0] rd_data;

    assign m_clip = (largest_part > query_total) ? query_total : largest_part;
    assign n_ext  = XW'(query_total);
    assign m_ext  = XW'(m_clip);

    assign rest = fn_reg - fm_reg;
    assign lim  = (fm_reg < rest) ? fm_reg : rest;
    assign sum  = {1'b0, prev_reg} + {1'b0, rd_data};

    always_comb
    begin
        if (fn_reg == '0)
        begin
            entry = COUNT_W'(1);
        end
        else if (fm_reg == '0)
        begin
            entry = '0;
        end
        else if (fm_reg > fn_reg)
        begin
            entry = prev_reg;
        end
        else
        begin
            entry = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        fn_next = fn_reg;
        fm_next = fm_reg;
        if (cmd.fill_start)
        begin
            fn_next = '0;
            fm_next = '0;
        end
        else if (cmd.fill_wr)
        begin
            if (fm_reg == LAST_IDX)
            begin
                fm_next = '0;
                fn_next = fn_reg + IW'(1);
            end
            else
            begin
                fm_next = fm_reg + IW'(1);
            end
        end
    end

    assign status.fill_last = (fn_reg == LAST_IDX) && (fm_reg == LAST_IDX);

    assign rd_en   = cmd.fill_rd || cmd.query_rd;
    assign rd_addr = cmd.query_rd ? {n_q_reg, m_q_reg} : {rest, lim};

    pct_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (cmd.fill_wr),
        .wr_addr ({fn_reg, fm_reg}),
        .wr_data (entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            n_q_reg <= n_ext[IW-1:0];
            m_q_reg <= m_ext[IW-1:0];
            oor_reg <= (int'(query_total) >= MAX_N);
        end
        fn_reg <= fn_next;
        fm_reg <= fm_next;
        if (cmd.fill_wr)
        begin
            prev_reg <= entry;
        end
        if (cmd.out_load)
        begin
            count_reg <= oor_reg ? '0 : rd_data;
        end
    end

    assign partition_count = count_reg;

endmodule

@@ src/partition_count_table.sv @@
// partition count table: p(n, m) with parts at most m, by table lookup
// first query after reset fills the table, MAX_N * MAX_N entries, each by a fill read then a fill write
// each query then shows its result after a table read state, then the output register load
// one query in flight at a time; the next is accepted once the result sits in the output register,
// so a new query waits until the last one is through, and longer when the output side stalls
// rst_n is asynchronous and clears the controller, including the table-filled flag
module partition_count_table #(
    parameter int MAX_N = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pct_pkg::QUERY_W-1:0]   query_total,
    input  logic [pct_pkg::QUERY_W-1:0]   largest_part,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pct_pkg::COUNT_W-1:0]   partition_count
);

    import pct_pkg::*;

    pct_cmd_t    cmd;
    pct_status_t status;

    pct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pct_dp #(
        .MAX_N (MAX_N)
    ) u_dp (
        .clk             (clk),
        .query_total     (query_total),
        .largest_part    (largest_part),
        .partition_count (partition_count),
        .cmd             (cmd),
        .status          (status)
    );

endmodule
